// ----- src/scmm_pkg.sv -----
// Shared types, address constants and boot ROM contents for the sound memory map.
package scmm_pkg;

  // Bus access kinds carried on in_mode
  typedef enum logic [1:0] {
    MODE_SOUND_RD = 2'd0,
    MODE_SOUND_WR = 2'd1,
    MODE_HOST_RD  = 2'd2,
    MODE_HOST_WR  = 2'd3
  } mode_t;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;

  // Sound-side I/O page 0x00F0-0x00FF
  localparam logic [11:0] IO_PAGE      = 12'h00F;
  // Control register (boot ROM select in bit 7)
  localparam logic [15:0] CTRL_ADDR    = 16'h00F1;
  // Mailbox ports 0x00F4-0x00F7, as a 4-byte-aligned group
  localparam logic [13:0] PORT_GROUP   = 14'h003D;
  // Host port window 0x2140-0x2143
  localparam logic [13:0] HOST_GROUP   = 14'h0850;
  // Boot ROM overlay 0xFFC0-0xFFFF
  localparam logic [9:0]  ROM_GROUP    = 10'h3FF;
  localparam int unsigned ROM_BIT_SEL  = 7;

  localparam logic [7:0] BOOT_ROM [0:63] = '{
    8'hCD, 8'hEF, 8'hBD, 8'hE8, 8'h00, 8'hC6, 8'h1D, 8'hD0,
    8'hFC, 8'h8F, 8'hAA, 8'hF4, 8'h8F, 8'hBB, 8'hF5, 8'h78,
    8'hCC, 8'hF4, 8'hD0, 8'hFB, 8'h2F, 8'h19, 8'hEB, 8'hF4,
    8'hD0, 8'hFC, 8'h7E, 8'hF4, 8'hD0, 8'h0B, 8'hE4, 8'hF5,
    8'hCB, 8'hF4, 8'hD7, 8'h00, 8'hFC, 8'hD0, 8'hF3, 8'hAB,
    8'h01, 8'h10, 8'hEF, 8'h7E, 8'hF4, 8'h10, 8'hEB, 8'hBA,
    8'hF6, 8'hDA, 8'h00, 8'hBA, 8'hF4, 8'hC4, 8'hF4, 8'hDD,
    8'h5D, 8'hD0, 8'hDB, 8'h1F, 8'h00, 8'h00, 8'hC0, 8'hFF
  };

endpackage

// ----- src/sound_cpu_memory_map.sv -----
// Top level: audio RAM, mailbox ports and boot ROM overlay of the sound processor bus.
// Read path: a read beat passes the RAM read register (or the stage 1 registers), then
//   the result register, before it shows on out_read_data/out_valid.
// Throughput: one beat per cycle, every cycle; busy is never raised.
// Reset (rst_n low, synchronous): ports cleared, boot ROM selected, no result pending.
//   Audio RAM is not cleared; its contents are undefined until written.
// The receiver cannot stall: each result is on the ports for exactly one cycle.
module sound_cpu_memory_map #(
  parameter int unsigned RAM_WORDS = 65536
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_mode,
  input  logic [scmm_pkg::ADDR_W-1:0]    in_address,
  input  logic [scmm_pkg::DATA_W-1:0]    in_write_data,
  output logic                           out_valid,
  output logic [scmm_pkg::DATA_W-1:0]    out_read_data
);
  import scmm_pkg::*;

  localparam int unsigned RAM_AW = $clog2(RAM_WORDS);

  // Audio RAM: one write and one registered read port
  logic [DATA_W-1:0] ram [RAM_WORDS];
  logic [DATA_W-1:0] ram_q_r;

  // Architectural state
  logic [DATA_W-1:0] port_r [4];
  logic              boot_sel_r;

  // Stage 1: read in flight, source select and non-RAM data
  logic              rd1_r;
  logic              use_ram_r;
  logic [DATA_W-1:0] side_r;

  // Stage 2: result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  // Decode of the incoming beat
  mode_t             mode;
  logic              accept;
  logic              is_io;
  logic              is_port;
  logic              is_ctrl;
  logic              rom_hit;
  logic              host_hit;
  logic              ram_we;
  logic              rd_nxt;
  logic              use_ram_nxt;
  logic [DATA_W-1:0] side_nxt;
  logic [RAM_AW-1:0] ram_idx;
  logic [1:0]        port_idx;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign mode     = mode_t'(in_mode);
  assign is_io    = (in_address[15:4] == IO_PAGE);
  assign is_port  = (in_address[15:2] == PORT_GROUP);
  assign is_ctrl  = (in_address == CTRL_ADDR);
  assign rom_hit  = (in_address[15:6] == ROM_GROUP);
  assign host_hit = (in_address[15:2] == HOST_GROUP);
  assign ram_idx  = in_address[RAM_AW-1:0];
  assign port_idx = in_address[1:0];
  // Every sound-side write lands in RAM, I/O page and ROM overlay included
  assign ram_we   = accept && (mode == MODE_SOUND_WR);
  assign rd_nxt   = accept && (mode == MODE_SOUND_RD || mode == MODE_HOST_RD);

  // Read source: sound reads use RAM unless the I/O page or selected boot ROM covers it
  always_comb begin
    use_ram_nxt = 1'b0;
    side_nxt    = '0;
    unique case (mode)
      MODE_SOUND_RD: begin
        if (is_io) begin
          if (is_port) side_nxt = port_r[port_idx];
        end else if (rom_hit && boot_sel_r) begin
          side_nxt = BOOT_ROM[in_address[5:0]];
        end else begin
          use_ram_nxt = 1'b1;
        end
      end
      MODE_HOST_RD: begin
        if (host_hit) side_nxt = port_r[port_idx];
      end
      default: begin
        side_nxt = '0;
      end
    endcase
  end

  // RAM array: no reset
  always_ff @(posedge clk) begin
    if (ram_we) ram[ram_idx] <= in_write_data;
    ram_q_r <= ram[ram_idx];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    use_ram_r  <= use_ram_nxt;
    side_r     <= side_nxt;
    out_data_r <= use_ram_r ? ram_q_r : side_r;
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd1_r       <= 1'b0;
      out_valid_r <= 1'b0;
      boot_sel_r  <= 1'b1;
      for (int i = 0; i < 4; i++) port_r[i] <= '0;
    end else begin
      rd1_r       <= rd_nxt;
      out_valid_r <= rd1_r;
      if (accept) begin
        if (mode == MODE_SOUND_WR) begin
          if (is_ctrl)      boot_sel_r       <= in_write_data[ROM_BIT_SEL];
          else if (is_port) port_r[port_idx] <= in_write_data;
        end else if (mode == MODE_HOST_WR && host_hit) begin
          port_r[port_idx] <= in_write_data;
        end
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // A result beat only follows a read in flight in stage 1
  a_valid_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(rd1_r))
    else $error("result beat without a read in flight");

  // Write beats never raise a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_SOUND_WR || in_mode == MODE_HOST_WR)) |=> !rd1_r)
    else $error("write beat produced a read");

  // Control write takes the ROM select from bit 7
  a_ctrl_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_SOUND_WR && in_address == CTRL_ADDR)
      |=> boot_sel_r == $past(in_write_data[ROM_BIT_SEL]))
    else $error("boot ROM select not updated by control write");

  // Host write to the first window address lands in port 0
  a_host_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_mode == MODE_HOST_WR && in_address[15:2] == HOST_GROUP
      && in_address[1:0] == 2'd0) |=> port_r[0] == $past(in_write_data))
    else $error("host write did not reach port 0");

endmodule

// ----- tb/tb_sound_cpu_memory_map.sv -----
// Self-checking bench for the sound processor memory map: queued bus beats, mirror-model checks.
module tb_sound_cpu_memory_map;
  import scmm_pkg::*;

  // Address map as seen from the sound and host sides
  localparam logic [15:0] SND_IO_LO   = 16'h00F0;
  localparam logic [15:0] SND_IO_HI   = 16'h00FF;
  localparam logic [15:0] SND_CTRL    = 16'h00F1;
  localparam logic [15:0] SND_PORT_LO = 16'h00F4;
  localparam logic [15:0] SND_PORT_HI = 16'h00F7;
  localparam logic [15:0] RAM_TOP     = 16'hFFBF;
  localparam logic [15:0] ROM_LO      = 16'hFFC0;
  localparam logic [15:0] ROM_HI      = 16'hFFFF;
  localparam logic [15:0] HOST_LO     = 16'h2140;
  localparam logic [15:0] HOST_HI     = 16'h2143;

  localparam int RANDOM_BEATS   = 1850;
  // Far above the longest sender gap plus the time a read takes through the block
  localparam int WATCHDOG_LIMIT = 400;
  localparam int DRAIN_CYCLES   = 8;

  // Our own copy of the 64-byte boot program
  localparam logic [7:0] ROM_IMAGE [0:63] = '{
    8'hCD, 8'hEF, 8'hBD, 8'hE8, 8'h00, 8'hC6, 8'h1D, 8'hD0,
    8'hFC, 8'h8F, 8'hAA, 8'hF4, 8'h8F, 8'hBB, 8'hF5, 8'h78,
    8'hCC, 8'hF4, 8'hD0, 8'hFB, 8'h2F, 8'h19, 8'hEB, 8'hF4,
    8'hD0, 8'hFC, 8'h7E, 8'hF4, 8'hD0, 8'h0B, 8'hE4, 8'hF5,
    8'hCB, 8'hF4, 8'hD7, 8'h00, 8'hFC, 8'hD0, 8'hF3, 8'hAB,
    8'h01, 8'h10, 8'hEF, 8'h7E, 8'hF4, 8'h10, 8'hEB, 8'hBA,
    8'hF6, 8'hDA, 8'h00, 8'hBA, 8'hF4, 8'hC4, 8'hF4, 8'hDD,
    8'h5D, 8'hD0, 8'hDB, 8'h1F, 8'h00, 8'h00, 8'hC0, 8'hFF
  };

  typedef struct {
    mode_t       mode;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } bus_beat_t;

  // A read byte still owed by the block, with the beat that asked for it
  typedef struct {
    logic [7:0]  data;
    mode_t       mode;
    logic [15:0] addr;
  } read_owed_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic [7:0]  out_read_data;

  sound_cpu_memory_map dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_mode       (in_mode),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  bus_beat_t  beat_q[$];      // beats waiting to be driven
  read_owed_t read_owed_q[$]; // read bytes predicted, not yet returned

  // Mirror of the block's state, updated as beats are accepted
  logic [7:0] mirror_ram [0:65535];
  logic [7:0] mirror_port [0:3];
  logic       mirror_rom_on;

  // Shadow kept while building stimulus, so no read ever lands on unwritten RAM
  bit          gen_written [0:65535];
  logic [15:0] gen_wr_list[$];
  logic        gen_rom_on;

  bit go;          // set once reset is over
  bit beat_taken;  // the beat on the input ports was accepted at the last rising edge
  int burst_left;
  int gap_left;
  int idle_cycles;
  int err_count;
  read_owed_t owed;

  // Mirror of one accepted bus beat; reads leave a byte in read_owed_q
  task automatic map_access(input mode_t m, input logic [15:0] a, input logic [7:0] d);
    logic [7:0] rd;
    logic       host_hit;
    host_hit = (a >= HOST_LO) && (a <= HOST_HI);
    rd = 8'h00;
    case (m)
      MODE_SOUND_RD: begin
        if (a >= SND_IO_LO && a <= SND_IO_HI) begin
          // Only the mailbox ports answer in the I/O page; the rest reads as zero
          if (a >= SND_PORT_LO && a <= SND_PORT_HI) rd = mirror_port[a[1:0]];
        end else if (a >= ROM_LO && mirror_rom_on) begin
          rd = ROM_IMAGE[a[5:0]];
        end else begin
          rd = mirror_ram[a];
        end
        read_owed_q.push_back('{data: rd, mode: m, addr: a});
      end
      MODE_SOUND_WR: begin
        if (a == SND_CTRL) mirror_rom_on = d[7];
        else if (a >= SND_PORT_LO && a <= SND_PORT_HI) mirror_port[a[1:0]] = d;
        // Every sound-side write lands in RAM, under the ROM and the I/O page too
        mirror_ram[a] = d;
      end
      MODE_HOST_RD: begin
        if (host_hit) rd = mirror_port[a[1:0]];
        read_owed_q.push_back('{data: rd, mode: m, addr: a});
      end
      default: begin
        if (host_hit) mirror_port[a[1:0]] = d;
      end
    endcase
  endtask

  // Queue a beat; a sound read of unwritten RAM moves to a written byte, or to a port if none
  task automatic queue_beat(input mode_t m, input logic [15:0] a, input logic [7:0] d);
    logic ok;
    if (m == MODE_SOUND_RD) begin
      ok = (a >= SND_IO_LO && a <= SND_IO_HI) || (a >= ROM_LO && gen_rom_on) || gen_written[a];
      if (!ok) begin
        if (gen_wr_list.size() > 0) a = gen_wr_list[$urandom_range(gen_wr_list.size() - 1)];
        else a = SND_PORT_LO;
      end
    end
    if (m == MODE_SOUND_WR) begin
      if (!gen_written[a]) begin
        gen_written[a] = 1'b1;
        gen_wr_list.push_back(a);
      end
      if (a == SND_CTRL) gen_rom_on = d[7];
    end
    beat_q.push_back('{mode: m, addr: a, wdata: d});
  endtask

  // Addresses weighted toward the interesting corners of the map
  function automatic logic [15:0] pick_addr();
    logic [15:0] a;
    case ($urandom_range(9))
      0, 1, 2: a = 16'($urandom_range(16'hFFFF));
      3, 4:    a = SND_IO_LO + 16'($urandom_range(15));
      5, 6:    a = ROM_LO + 16'($urandom_range(63));
      7, 8:    a = HOST_LO - 16'd4 + 16'($urandom_range(11));  // window and its edges
      default: a = 16'hFF80 + 16'($urandom_range(127));        // RAM just below the ROM, and the ROM
    endcase
    return a;
  endfunction

  // Driver: changes inputs at the falling edge, one beat per burst slot
  always @(negedge clk) begin
    if (start && !beat_taken) begin
      // Beat not yet taken: hold it (busy is never expected, but stay correct)
    end else begin
      if (beat_taken) begin
        beat_q.pop_front();
        beat_taken = 1'b0;
      end
      if (!go || beat_q.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else begin
        start         <= 1'b1;
        in_mode       <= beat_q[0].mode;
        in_address    <= beat_q[0].addr;
        in_write_data <= beat_q[0].wdata;
        if (burst_left <= 1) begin
          // New burst: sometimes long with no gap, so back-to-back stretches occur
          burst_left = ($urandom_range(4) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
          gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Monitor: results first, then the beat accepted at this edge, then the watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (read_owed_q.size() == 0) begin
        $display("%0t: stray result, expected none, actual read_data %02h", $time, out_read_data);
        err_count++;
      end else begin
        owed = read_owed_q.pop_front();
        if (out_read_data !== owed.data) begin
          $display("%0t: read_data mismatch (%s addr %04h): expected %02h, actual %02h",
                   $time, owed.mode.name(), owed.addr, owed.data, out_read_data);
          err_count++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      map_access(mode_t'(in_mode), in_address, in_write_data);
      beat_taken = 1'b1;
    end
    if (rst_n && !(start && !busy) && !out_valid) idle_cycles++;
    else idle_cycles = 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat and no result for %0d cycles", $time, idle_cycles);
      $display("** sound_cpu_memory_map: FAILED **");
      $finish;
    end
  end

  initial begin
    mode_t m;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_mode       = MODE_SOUND_RD;
    in_address    = '0;
    in_write_data = '0;
    go            = 1'b0;
    beat_taken    = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    idle_cycles   = 0;
    err_count     = 0;
    for (int i = 0; i < 4; i++) mirror_port[i] = 8'h00;
    mirror_rom_on = 1'b1;
    gen_rom_on    = 1'b1;

    // Directed beats: state after reset, ROM overlay, I/O page, host window
    queue_beat(MODE_SOUND_RD, ROM_LO, 8'hFF);        // first ROM byte
    queue_beat(MODE_SOUND_RD, ROM_HI, 8'h00);        // last ROM byte
    queue_beat(MODE_SOUND_RD, SND_PORT_LO, 8'h00);   // ports clear after reset
    queue_beat(MODE_SOUND_RD, SND_PORT_HI, 8'hFF);
    queue_beat(MODE_SOUND_RD, SND_IO_LO, 8'h00);     // unmapped I/O reads as zero
    queue_beat(MODE_SOUND_RD, SND_IO_HI, 8'h00);
    queue_beat(MODE_HOST_RD, HOST_LO, 8'h00);
    queue_beat(MODE_HOST_RD, HOST_HI - 16'd4 + 16'd4, 8'h00);
    queue_beat(MODE_HOST_RD, HOST_LO - 16'd1, 8'h00); // host miss, both edges
    queue_beat(MODE_HOST_RD, HOST_HI + 16'd1, 8'h00);
    queue_beat(MODE_HOST_WR, HOST_LO + 16'd1, 8'hA5);
    queue_beat(MODE_SOUND_RD, SND_PORT_LO + 16'd1, 8'h00);
    queue_beat(MODE_HOST_WR, HOST_HI + 16'd1, 8'h5A); // ignored
    queue_beat(MODE_SOUND_WR, SND_PORT_LO + 16'd2, 8'hFF);
    queue_beat(MODE_HOST_RD, HOST_LO + 16'd2, 8'h00);
    queue_beat(MODE_SOUND_WR, ROM_LO, 8'h12);         // stored under the ROM
    queue_beat(MODE_SOUND_WR, ROM_HI, 8'h34);
    queue_beat(MODE_SOUND_RD, ROM_LO, 8'h00);         // ROM still wins
    queue_beat(MODE_SOUND_WR, SND_CTRL, 8'h7F);       // bit 7 clear: ROM off
    queue_beat(MODE_SOUND_RD, ROM_HI, 8'h00);         // RAM under the ROM now
    queue_beat(MODE_SOUND_RD, SND_CTRL, 8'hFF);       // control reads as zero
    queue_beat(MODE_SOUND_WR, 16'h0000, 8'h55);
    queue_beat(MODE_SOUND_WR, RAM_TOP, 8'hAA);
    queue_beat(MODE_SOUND_RD, 16'h0000, 8'h00);
    queue_beat(MODE_SOUND_RD, RAM_TOP, 8'h00);
    queue_beat(MODE_SOUND_WR, SND_CTRL, 8'h80);       // ROM back on
    queue_beat(MODE_SOUND_RD, ROM_HI, 8'h00);

    // Random beats over the whole map; reads of RAM go to bytes already written
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      m = mode_t'($urandom_range(3));
      queue_beat(m, pick_addr(), 8'($urandom_range(255)));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    go = 1'b1;

    while (beat_q.size() != 0 || start) @(posedge clk);
    while (read_owed_q.size() != 0) @(posedge clk);
    // Let any late or stray result show before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("** sound_cpu_memory_map: PASSED **");
    end else begin
      $display("** sound_cpu_memory_map: FAILED **");
    end
    $finish;
  end

endmodule
